// ===== rtl/core/stcg_pkg.sv =====
package stcg_pkg;

  localparam int unsigned MaxVerticesDef = 256;
  localparam int unsigned MaxGridDef     = 16;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned PointW   = 25;
  localparam int unsigned SideW    = 16;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned H2W      = 2 * HalfW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW   = 9;
  localparam int unsigned FracW    = 17;
  localparam int unsigned FracShift = 16;

  localparam logic [CfgIdxW-1:0] RegPointCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGridSize     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTapeHalfWidth = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [8:0]  PointCountRst = 9'd0;
  localparam logic [4:0]  GridSizeRst   = 5'd2;
  localparam logic [15:0] HalfWidthRst  = 16'd2560;

  // One point-to-segment test.
  typedef struct packed {
    logic                     last;
    logic signed [PointW-1:0] px;
    logic signed [PointW-1:0] py;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
  } seg_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } seg_res_t;

endpackage

// ===== rtl/core/sensor_tape_coverage_grid.sv =====
// Counts the points of an n-by-n grid across a square sensor that lie within
// the tape half width of a stored polyline. A vertex load is written to the
// vertex store at its transfer. A query runs a divide for the grid step, then
// n * n * (point_count - 1) segment tests, one test per cycle through a
// seven-stage distance pipeline fed by a dual-read vertex memory, then a
// drain and a second divide for the Q16 fraction. The next item is taken
// once the query has its result in the output register.
module sensor_tape_coverage_grid #(
  parameter int unsigned MaxVertices = stcg_pkg::MaxVerticesDef,
  parameter int unsigned MaxGrid     = stcg_pkg::MaxGridDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stcg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [stcg_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [7:0]                      vertex_index_i,
  input  logic signed [stcg_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [stcg_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [stcg_pkg::CoordW-1:0] sensor_x_i,
  input  logic signed [stcg_pkg::CoordW-1:0] sensor_y_i,
  input  logic [stcg_pkg::SideW-1:0]      sensor_side_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [stcg_pkg::CountW-1:0]     inside_count_o,
  output logic [stcg_pkg::FracW-1:0]      coverage_fraction_o
);

  import stcg_pkg::*;

  localparam int unsigned AW  = $clog2(MaxVertices);
  localparam int unsigned GW  = $clog2(MaxGrid);
  localparam int unsigned NBW = $clog2(MaxGrid + 1);
  localparam int unsigned CW  = $clog2(MaxGrid * MaxGrid + 1);
  localparam int unsigned DW  = CW + FracShift;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDiv1  = 6'b000010,
    StRun   = 6'b000100,
    StDrain = 6'b001000,
    StDiv2  = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [8:0]  point_count_q;
  logic [4:0]  grid_size_q;
  logic [15:0] half_width_q;

  logic signed [CoordW-1:0] cx_q, cy_q;
  logic [HalfW-2:0] half_q;
  logic [NBW-1:0]   n_q;
  logic [GW-1:0]    nm1_q;
  logic [AW-1:0]    pcm2_q;
  logic             pc_ok_q;
  logic [H2W-1:0]   h2_q;
  logic [SideW-1:0] step_q;
  logic [GW-1:0]    stepr_q;

  logic [GW-1:0]    ix_q, iy_q;
  logic [AW-1:0]    k_q;
  logic [SideW-1:0] qx_q, qy_q;
  logic [GW-1:0]    rx_q, ry_q;

  logic [CW-1:0]    count_q;
  logic             any_q;
  logic             out_valid_q;
  logic [CountW-1:0] out_count_q;
  logic [FracW-1:0]  out_frac_q;

  logic [2*CoordW-1:0] mem [MaxVertices];
  logic [2*CoordW-1:0] rd_a_q, rd_b_q;
  logic                iss_v_q, iss_last_q;
  logic signed [PointW-1:0] iss_px_q, iss_py_q;

  logic             in_xfer, query_go, load_go, issue, seg_last;
  logic [NBW-1:0]   n_d;
  int               pc_int;
  logic             div_start, div_done;
  logic [DW-1:0]    div_a, div_b, div_q, div_r;
  logic [SideW-1:0] qx_n, qy_n;
  logic [GW-1:0]    rx_n, ry_n;
  logic [GW:0]      rsx, rsy;
  logic             pipe_busy, out_load;
  seg_req_t         req;
  seg_res_t         res;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign query_go   = in_xfer & (operation_i == OpQuery);
  assign load_go    = in_xfer & (operation_i == OpLoad);
  assign issue      = (state_q == StRun);
  assign seg_last   = (k_q == pcm2_q);
  assign out_load   = (state_q == StDone) & (~out_valid_q | out_ready_i);

  always_comb begin
    if (grid_size_q < 5'd2) begin
      n_d = NBW'(2);
    end else if (int'(grid_size_q) > int'(MaxGrid)) begin
      n_d = NBW'(MaxGrid);
    end else begin
      n_d = NBW'(grid_size_q);
    end
    pc_int = (int'(point_count_q) > int'(MaxVertices)) ? int'(MaxVertices)
                                                       : int'(point_count_q);
  end

  // Grid offsets advance by the quotient and remainder of side / (n - 1).
  always_comb begin
    rsx = (GW+1)'(rx_q) + (GW+1)'(stepr_q);
    rsy = (GW+1)'(ry_q) + (GW+1)'(stepr_q);
    if (rsx >= (GW+1)'(nm1_q)) begin
      rx_n = GW'(rsx - (GW+1)'(nm1_q));
      qx_n = qx_q + step_q + SideW'(1);
    end else begin
      rx_n = GW'(rsx);
      qx_n = qx_q + step_q;
    end
    if (rsy >= (GW+1)'(nm1_q)) begin
      ry_n = GW'(rsy - (GW+1)'(nm1_q));
      qy_n = qy_q + step_q + SideW'(1);
    end else begin
      ry_n = GW'(rsy);
      qy_n = qy_q + step_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_a     = DW'(sensor_side_i);
    div_b     = DW'(n_d - NBW'(1));
    case (state_q)
      StIdle: begin
        if (query_go) begin
          div_start = 1'b1;
          state_d   = StDiv1;
        end
      end
      StDiv1: begin
        if (div_done) begin
          state_d = pc_ok_q ? StRun : StDrain;
        end
      end
      StRun: begin
        if (seg_last && ix_q == nm1_q && iy_q == nm1_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        div_a = {count_q, FracShift'(0)};
        div_b = DW'(n_q) * DW'(n_q);
        if (!iss_v_q && !pipe_busy) begin
          div_start = 1'b1;
          state_d   = StDiv2;
        end
      end
      StDiv2: begin
        if (div_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      point_count_q <= PointCountRst;
      grid_size_q   <= GridSizeRst;
      half_width_q  <= HalfWidthRst;
      out_valid_q   <= 1'b0;
      iss_v_q       <= 1'b0;
      count_q       <= '0;
      any_q         <= 1'b0;
      n_q           <= NBW'(2);
      k_q           <= '0;
      ix_q          <= '0;
      iy_q          <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPointCount:    point_count_q <= cfg_wdata_i[8:0];
          RegGridSize:      grid_size_q   <= cfg_wdata_i[4:0];
          RegTapeHalfWidth: half_width_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      iss_v_q <= issue;
      if (query_go) begin
        n_q     <= n_d;
        count_q <= '0;
        any_q   <= 1'b0;
      end else if (res.valid) begin
        if (res.last) begin
          count_q <= count_q + CW'(any_q | res.hit);
          any_q   <= 1'b0;
        end else begin
          any_q <= any_q | res.hit;
        end
      end
      if (query_go) begin
        k_q  <= '0;
        ix_q <= '0;
        iy_q <= '0;
      end else if (issue) begin
        if (seg_last) begin
          k_q <= '0;
          if (ix_q == nm1_q) begin
            ix_q <= '0;
            iy_q <= iy_q + GW'(1);
          end else begin
            ix_q <= ix_q + GW'(1);
          end
        end else begin
          k_q <= k_q + AW'(1);
        end
      end
    end
  end

  // Query operands and grid position; loaded at the query transfer.
  always_ff @(posedge clk_i) begin
    if (query_go) begin
      cx_q    <= sensor_x_i;
      cy_q    <= sensor_y_i;
      half_q  <= sensor_side_i[SideW-1:1];
      nm1_q   <= GW'(n_d - NBW'(1));
      pc_ok_q <= (pc_int >= 2);
      pcm2_q  <= AW'(pc_int - 2);
      h2_q    <= half_width_q * half_width_q;
      qx_q    <= '0;
      qy_q    <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
    end else if (issue && seg_last) begin
      if (ix_q == nm1_q) begin
        qx_q <= '0;
        rx_q <= '0;
        qy_q <= qy_n;
        ry_q <= ry_n;
      end else begin
        qx_q <= qx_n;
        rx_q <= rx_n;
      end
    end
    if (state_q == StDiv1 && div_done) begin
      step_q  <= SideW'(div_q);
      stepr_q <= GW'(div_r);
    end
    if (out_load) begin
      out_count_q <= CountW'(count_q);
      out_frac_q  <= FracW'(div_q);
    end
  end

  // Vertex store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (load_go && int'(vertex_index_i) < int'(MaxVertices)) begin
      mem[AW'(vertex_index_i)] <= {vertex_x_i, vertex_y_i};
    end
    rd_a_q     <= mem[k_q];
    rd_b_q     <= mem[k_q + AW'(1)];
    iss_last_q <= seg_last;
    iss_px_q   <= PointW'(cx_q) + $signed(PointW'(qx_q)) - $signed(PointW'(half_q));
    iss_py_q   <= PointW'(cy_q) + $signed(PointW'(qy_q)) - $signed(PointW'(half_q));
  end

  always_comb begin
    req.last = iss_last_q;
    req.px   = iss_px_q;
    req.py   = iss_py_q;
    req.ax   = $signed(rd_a_q[2*CoordW-1:CoordW]);
    req.ay   = $signed(rd_a_q[CoordW-1:0]);
    req.bx   = $signed(rd_b_q[2*CoordW-1:CoordW]);
    req.by   = $signed(rd_b_q[CoordW-1:0]);
  end

  stcg_div #(
    .Width(DW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_q),
    .rem_o     (div_r)
  );

  stcg_seg_pipe u_seg_pipe (
    .clk_i,
    .rst_ni,
    .h2_i       (h2_q),
    .req_valid_i(iss_v_q),
    .req_i      (req),
    .res_o      (res),
    .busy_o     (pipe_busy)
  );

  assign out_valid_o         = out_valid_q;
  assign inside_count_o      = out_count_q;
  assign coverage_fraction_o = out_frac_q;

  // A new item is only taken with the distance pipeline empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !pipe_busy)
    else $error("item taken while segment tests are in flight");

  // The divider only finishes in one of the two states that wait for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv1 || state_q == StDiv2))
    else $error("divider finished outside a divide state");

  // No more points can be counted than the grid holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(n_q) * 32'(n_q))
    else $error("inside count exceeds grid size");

  // Segment tests are issued only while running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_v_q |-> $past(state_q) == StRun)
    else $error("segment test issued outside run state");

endmodule

// ===== rtl/core/stcg_div.sv =====
module stcg_div #(
  parameter int unsigned Width = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [Width-1:0] quot_q;
  logic [Width-1:0] rem_q;
  logic [Width-1:0] dvs_q;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted = {rem_q, quot_q[Width-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = ~diff[Width];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(Width);
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[Width-2:0], ge};
      rem_q  <= ge ? diff[Width-1:0] : shifted[Width-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/stcg_seg_pipe.sv =====
module stcg_seg_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [stcg_pkg::H2W-1:0]      h2_i,
  input  logic                          req_valid_i,
  input  stcg_pkg::seg_req_t            req_i,
  output stcg_pkg::seg_res_t            res_o,
  output logic                          busy_o
);

  import stcg_pkg::*;

  logic [7:1] v_q;
  logic [7:1] l_q;

  // Stage 1: differences.
  logic signed [24:0] vx_q, vy_q;
  logic signed [25:0] wx_q, wy_q, dx_q, dy_q;
  // Stage 2: products.
  logic signed [49:0] vxx_q, vyy_q;
  logic signed [50:0] dotx_q, doty_q, cra_q, crb_q;
  logic signed [51:0] wxx_q, wyy_q, dxx_q, dyy_q;
  // Stage 3: sums.
  logic        [49:0] len2_q;
  logic signed [51:0] dot_q, cross_q;
  logic        [51:0] dw2_q, de2_q;
  // Stage 4: case selection.
  logic               usec4_q, nhit4_q;
  logic        [51:0] ucross_q;
  logic        [49:0] len2b_q;
  // Stage 5: partial products.
  logic               usec5_q, nhit5_q;
  logic        [51:0] p11_q, p10_q, p00_q;
  logic        [56:0] q1_q, q0_q;
  // Stage 6: full products.
  logic               usec6_q, nhit6_q;
  logic       [103:0] sq_q;
  logic        [81:0] rhs_q;
  // Stage 7: decision.
  logic               hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      l_q <= '0;
    end else begin
      v_q <= {v_q[6:1], req_valid_i};
      l_q <= {l_q[6:1], req_i.last};
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q <= PointW'(req_i.bx) - PointW'(req_i.ax);
    vy_q <= PointW'(req_i.by) - PointW'(req_i.ay);
    wx_q <= 26'(req_i.px) - 26'(req_i.ax);
    wy_q <= 26'(req_i.py) - 26'(req_i.ay);
    dx_q <= 26'(req_i.px) - 26'(req_i.bx);
    dy_q <= 26'(req_i.py) - 26'(req_i.by);

    vxx_q  <= vx_q * vx_q;
    vyy_q  <= vy_q * vy_q;
    dotx_q <= wx_q * vx_q;
    doty_q <= wy_q * vy_q;
    cra_q  <= wx_q * vy_q;
    crb_q  <= wy_q * vx_q;
    wxx_q  <= wx_q * wx_q;
    wyy_q  <= wy_q * wy_q;
    dxx_q  <= dx_q * dx_q;
    dyy_q  <= dy_q * dy_q;

    len2_q  <= $unsigned(vxx_q) + $unsigned(vyy_q);
    dot_q   <= 52'(dotx_q) + 52'(doty_q);
    cross_q <= 52'(cra_q) - 52'(crb_q);
    dw2_q   <= $unsigned(wxx_q) + $unsigned(wyy_q);
    de2_q   <= $unsigned(dxx_q) + $unsigned(dyy_q);

    // Zero-length segment or projection at or before the start: start point.
    if (len2_q == '0 || dot_q[51] || dot_q == '0) begin
      usec4_q <= 1'b0;
      nhit4_q <= dw2_q <= 52'(h2_i);
    end else if (dot_q >= $signed({2'b00, len2_q})) begin
      usec4_q <= 1'b0;
      nhit4_q <= de2_q <= 52'(h2_i);
    end else begin
      usec4_q <= 1'b1;
      nhit4_q <= 1'b0;
    end
    ucross_q <= cross_q[51] ? $unsigned(-cross_q) : $unsigned(cross_q);
    len2b_q  <= len2_q;

    usec5_q <= usec4_q;
    nhit5_q <= nhit4_q;
    p11_q   <= ucross_q[51:26] * ucross_q[51:26];
    p10_q   <= ucross_q[51:26] * ucross_q[25:0];
    p00_q   <= ucross_q[25:0] * ucross_q[25:0];
    q1_q    <= h2_i * len2b_q[49:25];
    q0_q    <= h2_i * len2b_q[24:0];

    usec6_q <= usec5_q;
    nhit6_q <= nhit5_q;
    sq_q    <= (104'(p11_q) << 52) + (104'(p10_q) << 27) + 104'(p00_q);
    rhs_q   <= (82'(q1_q) << 25) + 82'(q0_q);

    hit_q <= usec6_q ? (sq_q <= 104'(rhs_q)) : nhit6_q;
  end

  always_comb begin
    res_o.valid = v_q[7];
    res_o.last  = l_q[7];
    res_o.hit   = hit_q;
  end

  assign busy_o = |v_q;

endmodule

// ===== verif/tb_sensor_tape_coverage_grid.sv =====
module tb_sensor_tape_coverage_grid;
  import stcg_pkg::*;

  // An index past the end of the register list.
  localparam logic [CfgIdxW-1:0] RegBeyondList = 2'd3;

  class tape_coverage_book;
    int          vx_mem[256];
    int          vy_mem[256];
    int unsigned n_points = 0;
    int unsigned n_grid   = 2;
    int unsigned half_w   = 2560;
    int unsigned want_count[$];
    int unsigned want_frac[$];
    int          errors = 0;

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == RegPointCount) n_points = val[8:0];
      else if (idx == RegGridSize) n_grid = val[4:0];
      else if (idx == RegTapeHalfWidth) half_w = val;
    endfunction

    // Exact point-to-segment test with the projection clamped to the ends.
    function bit near_segment(longint px, longint py, longint ax, longint ay,
                              longint bx, longint by, longint h2);
      longint vx, vy, wx, wy, len2, dot, cr, dx, dy;
      logic [127:0] lhs, rhs;
      vx = bx - ax;
      vy = by - ay;
      wx = px - ax;
      wy = py - ay;
      len2 = vx * vx + vy * vy;
      dot = wx * vx + wy * vy;
      if (len2 == 0 || dot <= 0) return (wx * wx + wy * wy) <= h2;
      if (dot >= len2) begin
        dx = px - bx;
        dy = py - by;
        return (dx * dx + dy * dy) <= h2;
      end
      cr = wx * vy - wy * vx;
      if (cr < 0) cr = -cr;
      lhs = 128'(cr) * 128'(cr);
      rhs = 128'(h2) * 128'(len2);
      return lhs <= rhs;
    endfunction

    function int unsigned count_covered(longint cx, longint cy, longint side);
      int unsigned n, pc, cnt;
      longint half, sx, sy, h2;
      n = (n_grid < 2) ? 2 : (n_grid > 16 ? 16 : n_grid);
      pc = (n_points > 256) ? 256 : n_points;
      half = side / 2;
      h2 = longint'(half_w) * longint'(half_w);
      cnt = 0;
      if (pc < 2) return 0;
      for (int iy = 0; iy < n; iy++) begin
        sy = cy + (iy * side) / (n - 1) - half;
        for (int ix = 0; ix < n; ix++) begin
          sx = cx + (ix * side) / (n - 1) - half;
          for (int k = 0; k + 1 < pc; k++) begin
            if (near_segment(sx, sy, vx_mem[k], vy_mem[k], vx_mem[k+1], vy_mem[k+1], h2)) begin
              cnt++;
              break;
            end
          end
        end
      end
      return cnt;
    endfunction

    function void note_item(logic op, logic [7:0] idx, int vx, int vy,
                            int cx, int cy, int unsigned side);
      int unsigned cnt, n;
      if (op == OpLoad) begin
        vx_mem[idx] = vx;
        vy_mem[idx] = vy;
      end else begin
        n = (n_grid < 2) ? 2 : (n_grid > 16 ? 16 : n_grid);
        cnt = count_covered(cx, cy, side);
        want_count.push_back(cnt);
        want_frac.push_back((cnt << 16) / (n * n));
      end
    endfunction

    task check_result(int unsigned cnt, int unsigned frac);
      int unsigned ec, ef;
      if (want_count.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d", cnt));
      end else begin
        ec = want_count.pop_front();
        ef = want_frac.pop_front();
        if (cnt != ec) report_mismatch($sformatf("inside_count %0d, want %0d", cnt, ec));
        if (frac != ef) report_mismatch($sformatf("coverage_fraction %0d, want %0d", frac, ef));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                operation_i = 1'b0;
  logic [7:0]          vertex_index_i = '0;
  logic signed [CoordW-1:0] vertex_x_i = '0;
  logic signed [CoordW-1:0] vertex_y_i = '0;
  logic signed [CoordW-1:0] sensor_x_i = '0;
  logic signed [CoordW-1:0] sensor_y_i = '0;
  logic [SideW-1:0]    sensor_side_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CountW-1:0]   inside_count_o;
  logic [FracW-1:0]    coverage_fraction_o;

  tape_coverage_book book = new();
  bit   written[256];
  bit   calm = 1'b0;
  int   out_stall = 0;

  always #5 clk_i = ~clk_i;

  sensor_tape_coverage_grid dut (.*);

  // Result side: stalls a random number of cycles after each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        book.check_result(inside_count_o, coverage_fraction_o);
        out_stall = calm ? 0 : $urandom_range(0, 18);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(logic op, logic [7:0] idx, int vx, int vy,
                           int cx, int cy, int unsigned side);
    int gap;
    if ($urandom_range(0, 7) == 0) calm = ~calm;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    vertex_index_i <= idx;
    vertex_x_i     <= vx[23:0];
    vertex_y_i     <= vy[23:0];
    sensor_x_i     <= cx[23:0];
    sensor_y_i     <= cy[23:0];
    sensor_side_i  <= side[15:0];
    do @(posedge clk_i); while (!in_ready_o);
    book.note_item(op, idx, int'(signed'(vx[23:0])), int'(signed'(vy[23:0])),
                   int'(signed'(cx[23:0])), int'(signed'(cy[23:0])), side[15:0]);
    if (op == OpLoad) written[idx] = 1'b1;
  endtask

  task automatic load_vertex(int idx, int vx, int vy);
    send_item(OpLoad, idx[7:0], vx, vy, $urandom, $urandom, $urandom);
  endtask

  task automatic query(int cx, int cy, int unsigned side);
    send_item(OpQuery, 8'($urandom), $urandom, $urandom, cx, cy, side);
  endtask

  // Drains all results, then idles with no item offered.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (book.want_count.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[15:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    book.set_reg(idx, val[15:0]);
  endtask

  function automatic int local_coord();
    return $urandom_range(0, 40000) - 20000;
  endfunction

  initial begin
    int pc, k, base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short polyline straight after reset.
    query(0, 0, 1000);
    load_vertex(0, -8388608, 8388607);
    load_vertex(1, 8388607, -8388608);
    load_vertex(2, 8388607, -8388608);
    load_vertex(3, 0, 0);
    load_vertex(255, 1234, -5678);
    settle();
    write_reg(RegPointCount, 1);
    query(0, 0, 65535);
    settle();
    write_reg(RegPointCount, 4);
    write_reg(RegBeyondList, 12345);
    query(0, 0, 0);
    query(0, 0, 65535);
    query(-8388608, -8388608, 65535);
    query(8388607, -8388608, 100);
    settle();
    write_reg(RegGridSize, 31);
    write_reg(RegTapeHalfWidth, 0);
    query(0, 0, 65535);
    query(8388607, -8388608, 0);
    settle();
    write_reg(RegGridSize, 1);
    write_reg(RegTapeHalfWidth, 65535);
    query(0, 0, 65535);
    query(100, 100, 30000);
    settle();
    write_reg(RegGridSize, 0);
    query(-8388608, 8388607, 65535);
    settle();

    // Random phases over small polylines with queries aimed at the tape.
    for (int ph = 0; ph < 3; ph++) begin
      pc = $urandom_range(0, 10);
      write_reg(RegPointCount, pc);
      write_reg(RegGridSize, $urandom_range(0, 31));
      write_reg(RegTapeHalfWidth, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 5000));
      for (int i = 0; i < pc; i++)
        if (!written[i] || $urandom_range(0, 2) == 0) load_vertex(i, local_coord(), local_coord());
      for (int i = 0; i < 12; i++) begin
        case ($urandom_range(0, 9))
          0: load_vertex($urandom_range(0, 255), $urandom, $urandom);
          1, 2: begin
            k = $urandom_range(0, (pc > 0) ? pc - 1 : 0);
            load_vertex(k, local_coord(), local_coord());
          end
          3: query($urandom, $urandom, $urandom_range(0, 65535));
          default: begin
            k = $urandom_range(0, (pc > 0) ? pc - 1 : 0);
            query(book.vx_mem[k] + $urandom_range(0, 8000) - 4000,
                  book.vy_mem[k] + $urandom_range(0, 8000) - 4000,
                  $urandom_range(0, 12000));
          end
        endcase
      end
      settle();
    end

    // Longer polyline under the largest grid, then under a small one.
    base = local_coord();
    for (int i = 0; i < 32; i++)
      load_vertex(i, base + i * 300, local_coord() / 4);
    settle();
    write_reg(RegPointCount, 32);
    write_reg(RegGridSize, 16);
    write_reg(RegTapeHalfWidth, 3000);
    query(base + 4000, 0, 20000);
    settle();
    write_reg(RegGridSize, 3);
    query(base + 8000, 1000, 65535);
    query($urandom, $urandom, $urandom_range(0, 65535));
    settle();
    repeat (50) @(posedge clk_i);

    while (book.want_count.size() > 0) begin
      book.report_mismatch("result never arrived");
      void'(book.want_count.pop_front());
      void'(book.want_frac.pop_front());
    end
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
